// File: sv/ucfc_pkg.sv
// Shared types and constants for the UART command frame checker.
package ucfc_pkg;

  localparam int BYTE_W = 8;
  localparam int HIDX_W = 5;

  localparam logic [BYTE_W-1:0] START_MARK = 8'hAF;
  localparam logic [BYTE_W-1:0] END_MARK   = 8'hDF;
  localparam logic [BYTE_W-1:0] BROADCAST  = 8'hFF;
  localparam logic [BYTE_W-1:0] LOW_FIRST  = 8'h01;
  localparam logic [BYTE_W-1:0] LOW_LAST   = 8'h0A;
  localparam logic [BYTE_W-1:0] HIGH_FIRST = 8'hE5;
  localparam logic [BYTE_W-1:0] HIGH_LAST  = 8'hEC;
  localparam logic [HIDX_W-1:0] HIGH_BASE  = 5'd10;
  localparam logic [BYTE_W-1:0] ADDR_RESET = 8'hFF;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPT   = 3'd0,
    ST_ADDR_ERR = 3'd1,
    ST_CMD_ERR  = 3'd2,
    ST_DELIM    = 3'd3,
    ST_LENGTH   = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [HIDX_W-1:0]   handler_index;
    logic [BYTE_W-1:0]   command_code;
    logic [BYTE_W-1:0]   argument;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] arg;
    logic [BYTE_W-1:0] last;
  } frame_view_t;

endpackage

// File: sv/ucfc_ifs.sv
// Valid/ready channel interfaces for input items, result items and configuration.
interface ucfc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [ucfc_pkg::BYTE_W-1:0]  rx_byte;
  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface ucfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [ucfc_pkg::HIDX_W-1:0]  handler_index;
  logic [ucfc_pkg::BYTE_W-1:0]  command_code;
  logic [ucfc_pkg::BYTE_W-1:0]  argument;
  modport source (output valid, output status, output handler_index,
                  output command_code, output argument, input ready);
  modport sink (input valid, input status, input handler_index,
                input command_code, input argument, output ready);
endinterface

interface ucfc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ucfc_pkg::BYTE_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/uart_command_frame_checker.sv
// Top level of the UART command frame checker.
// Each input item is either a received byte (func 0) or an idle timeout
// (func 1). Bytes go into a frame buffer of BUFFER_DEPTH-1 entries; bytes
// beyond that are dropped. A timeout on a non-empty frame checks it and emits
// one result item (status, handler index, command code, argument); a timeout
// on an empty frame emits nothing. One item is taken per clock cycle while
// in_ch.ready is high; the check is combinational between the frame buffer
// and a result register. A one-entry skid register behind the result
// register lets input continue while a result waits; in_ch.ready drops only
// when both hold a result. own_address is written through cfg_ch and resets
// to 0xFF; the user must write it only while the block is idle, and the block itself does not enforce this.
module uart_command_frame_checker #(
  parameter int FRAME_LEN    = 5,
  parameter int BUFFER_DEPTH = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  ucfc_in_if.sink    in_ch,
  ucfc_out_if.source out_ch,
  ucfc_cfg_if.sink   cfg_ch
);
  import ucfc_pkg::*;

  localparam int KEEP  = BUFFER_DEPTH - 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH);
  localparam int IDX_W = $clog2(KEEP);

  logic [BYTE_W-1:0] frame_r [KEEP];
  logic [CNT_W-1:0]  count_r;
  logic [BYTE_W-1:0] own_addr_r;
  result_t           out_r;
  result_t           skd_r;
  logic              out_vld_r;
  logic              skd_vld_r;

  logic              in_fire;
  logic              pop;
  logic              push;
  logic              room;
  frame_view_t       view;
  result_t           res;

  assign in_ch.ready  = !skd_vld_r;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign pop          = out_vld_r && out_ch.ready;
  assign room         = (count_r < CNT_W'(KEEP));
  assign push         = in_fire && (in_ch.func == FUNC_TIMEOUT) && (count_r != '0);

  assign view.first = frame_r[0];
  assign view.addr  = frame_r[1];
  assign view.code  = frame_r[2];

  generate
    if (FRAME_LEN > 3) begin : g_arg
      assign view.arg = frame_r[3];
    end else begin : g_no_arg
      assign view.arg = '0;
    end
    if (FRAME_LEN - 1 < KEEP) begin : g_last
      assign view.last = frame_r[FRAME_LEN-1];
    end else begin : g_no_last
      assign view.last = '0;
    end
  endgenerate

  ucfc_check #(
    .FRAME_LEN (FRAME_LEN),
    .CNT_W     (CNT_W)
  ) u_check (
    .count       (count_r),
    .frame       (view),
    .own_address (own_addr_r),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.func == FUNC_BYTE) && room) begin
      frame_r[count_r[IDX_W-1:0]] <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_fire) begin
      if (in_ch.func == FUNC_TIMEOUT) begin
        count_r <= '0;
      end else if (room) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= ADDR_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      own_addr_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else if (pop || !out_vld_r) begin
      if (skd_vld_r) begin
        out_vld_r <= 1'b1;
        skd_vld_r <= 1'b0;
      end else begin
        out_vld_r <= push;
      end
    end else if (push) begin
      skd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_vld_r) begin
      if (skd_vld_r) begin
        out_r <= skd_r;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skd_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.handler_index = out_r.handler_index;
  assign out_ch.command_code  = out_r.command_code;
  assign out_ch.argument      = out_r.argument;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_vld_r |-> out_vld_r)
    else $error("skid holds an item while the result register is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(KEEP))
    else $error("byte count beyond buffer limit");

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.func == FUNC_TIMEOUT) |=> (count_r == '0))
    else $error("timeout item did not empty the frame");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_vld_r) |=> out_vld_r)
    else $error("closed frame did not reach the result register");

endmodule

// File: sv/ucfc_check.sv
// Frame check: length, delimiters, address and command lookup into one result.
module ucfc_check #(
  parameter int FRAME_LEN = 5,
  parameter int CNT_W     = 4
) (
  input  logic [CNT_W-1:0]            count,
  input  ucfc_pkg::frame_view_t       frame,
  input  logic [ucfc_pkg::BYTE_W-1:0] own_address,
  output ucfc_pkg::result_t           result
);
  import ucfc_pkg::*;

  logic              len_ok;
  logic              delim_ok;
  logic              addr_ok;
  logic              low_hit;
  logic              high_hit;
  logic [BYTE_W-1:0] high_off;

  assign len_ok   = (int'(count) == FRAME_LEN);
  assign delim_ok = (frame.first == START_MARK) && (frame.last == END_MARK);
  assign addr_ok  = (frame.addr == BROADCAST) || (frame.addr == own_address);
  assign high_off = frame.code - HIGH_FIRST;

  always_comb begin
    low_hit  = frame.code inside {[LOW_FIRST:LOW_LAST]};
    high_hit = frame.code inside {[HIGH_FIRST:HIGH_LAST]};
  end

  always_comb begin
    result = '0;
    if (!len_ok) begin
      result.status = ST_LENGTH;
    end else if (!delim_ok) begin
      result.status = ST_DELIM;
    end else begin
      result.command_code = frame.code;
      result.argument     = frame.arg;
      if (!addr_ok) begin
        result.status = ST_ADDR_ERR;
      end else if (low_hit) begin
        result.status        = ST_ACCEPT;
        result.handler_index = HIDX_W'(frame.code - LOW_FIRST);
      end else if (high_hit) begin
        result.status        = ST_ACCEPT;
        result.handler_index = HIDX_W'(high_off) + HIGH_BASE;
      end else begin
        result.status = ST_CMD_ERR;
      end
    end
  end

endmodule
